### design/gb9_pkg.sv
package gb9_pkg;

    localparam int COL_W      = 13;
    localparam int ROW_W      = 11;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 3;
    localparam int GEO_W      = 11;
    localparam int WT_W       = 16;
    localparam int NUM_WTS    = 5;
    localparam int VS_W       = 28;
    localparam int ACC_W      = 48;
    localparam int STEP_W     = 4;
    localparam int FRAC_SHIFT = 32;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_WT0    = 3'd2;
    localparam logic [IDX_W-1:0] REG_WT1    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WT2    = 3'd4;
    localparam logic [IDX_W-1:0] REG_WT3    = 3'd5;
    localparam logic [IDX_W-1:0] REG_WT4    = 3'd6;

    typedef logic [NUM_WTS-1:0][WT_W-1:0] gb9_weights_t;

    typedef struct packed {
        logic [7:0]       pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] ocol;
        logic             produce;
        logic             last;
    } gb9_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_VERT,
        BK_HORZ,
        BK_OUT
    } gb9_bk_state_t;

    function automatic logic [WT_W-1:0] tap_weight(input logic [STEP_W-1:0] tap_off,
                                                  input gb9_weights_t wts);
        logic [WT_W-1:0] w;
        w = '0;
        if (tap_off < STEP_W'(NUM_WTS)) begin
            w = wts[tap_off[2:0]];
        end
        return w;
    endfunction

endpackage

### design/gb9_fifo.sv
module gb9_fifo
    import gb9_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  gb9_item_t push_item,
    input  logic      pop,
    output gb9_item_t head_item,
    output logic      empty,
    output logic      full
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    gb9_item_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    always_comb begin
        empty       = (count_reg == '0);
        full        = (count_reg == (PW+1)'(DEPTH));
        head_item   = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/gb9_front.sv
module gb9_front
    import gb9_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int KERNEL_RADIUS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       pixel_in,
    input  logic             is_flush,
    input  logic [COL_W-1:0] eff_w,
    input  logic [ROW_W-1:0] eff_h,
    input  logic             restart,
    output logic             push,
    output gb9_item_t        item
);

    localparam int LW = $clog2(KERNEL_RADIUS * MAX_WIDTH + KERNEL_RADIUS + 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;
    logic [LW-1:0]    lead_reg, lead_next;
    logic [LW-1:0]    delay;
    logic             in_frame;
    logic             produce;
    logic             last;

    always_comb begin
        delay    = LW'(LW'(eff_w) * LW'(KERNEL_RADIUS) + LW'(KERNEL_RADIUS));
        in_frame = (row_reg < eff_h);
        produce  = (lead_reg == delay);
        last     = produce && (orow_reg == eff_h - 1'b1) && (ocol_reg == eff_w - 1'b1);
        push     = accept && !(in_frame && is_flush);

        item.pixel   = in_frame ? pixel_in : 8'd0;
        item.col     = col_reg;
        item.row     = row_reg;
        item.ocol    = ocol_reg;
        item.produce = produce;
        item.last    = last;

        col_next  = col_reg;
        row_next  = row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        lead_next = lead_reg;
        if (restart || (push && last)) begin
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
            lead_next = '0;
        end else if (push) begin
            if (col_reg == eff_w - 1'b1) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            if (produce) begin
                if (ocol_reg == eff_w - 1'b1) begin
                    ocol_next = '0;
                    orow_next = orow_reg + 1'b1;
                end else begin
                    ocol_next = ocol_reg + 1'b1;
                end
            end else begin
                lead_next = lead_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            lead_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            lead_reg <= lead_next;
        end
    end

endmodule

### design/gb9_back.sv
module gb9_back
    import gb9_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int KERNEL_RADIUS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  gb9_item_t        head_item,
    input  logic             empty,
    output logic             pop,
    input  logic [COL_W-1:0] eff_w,
    input  logic [ROW_W-1:0] eff_h,
    input  gb9_weights_t     wts,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_pixel,
    output logic             m_last
);

    localparam int NT    = 2 * KERNEL_RADIUS + 1;
    localparam int LANES = 2 * KERNEL_RADIUS;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int LIW   = $clog2(LANES);
    localparam int TIW   = $clog2(NT);
    localparam int MW    = VS_W + WT_W;

    logic [LANES*8-1:0] line_mem [MAX_WIDTH];
    logic [LANES*8-1:0] rd_reg;

    gb9_bk_state_t      state_reg, state_next;
    logic [STEP_W-1:0]  step_reg;
    gb9_item_t          cur_reg;
    logic [ACC_W-1:0]   prod_reg, acc_reg;
    logic [VS_W-1:0]    vs_reg [NT];
    logic [7:0]         res_reg;
    logic               out_valid_reg;
    logic [7:0]         out_pix_reg;
    logic               out_last_reg;

    logic [7:0]         lane [LANES];
    logic [LIW-1:0]     lane_idx;
    logic [TIW-1:0]     tap_idx;
    logic [STEP_W-1:0]  tap_off;
    logic               tap_ok;
    logic [VS_W-1:0]    mul_a;
    logic [ACC_W-1:0]   prod_next;
    logic [ACC_W-1:0]   sum;
    logic [COL_W:0]     hcol;
    logic               phase_done;
    logic               out_load;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lane[k] = rd_reg[k*8 +: 8];
        end
        lane_idx = (step_reg == '0) ? '0 : LIW'(step_reg - 1'b1);
        tap_idx  = TIW'(step_reg);
        tap_off  = (step_reg >= STEP_W'(KERNEL_RADIUS)) ? step_reg - STEP_W'(KERNEL_RADIUS)
                                                        : STEP_W'(KERNEL_RADIUS) - step_reg;
        hcol     = {1'b0, cur_reg.ocol} + (COL_W+1)'(step_reg);
        if (state_reg == BK_VERT) begin
            mul_a  = VS_W'((step_reg == '0) ? cur_reg.pixel : lane[lane_idx]);
            tap_ok = ({1'b0, cur_reg.row} >= (ROW_W+1)'(step_reg))
                  && (({1'b0, cur_reg.row} - (ROW_W+1)'(step_reg)) < {1'b0, eff_h});
        end else begin
            mul_a  = vs_reg[tap_idx];
            tap_ok = (hcol >= (COL_W+1)'(KERNEL_RADIUS))
                  && ((hcol - (COL_W+1)'(KERNEL_RADIUS)) < {1'b0, eff_w});
        end
        phase_done = (step_reg == STEP_W'(NT));
        prod_next  = '0;
        if (!phase_done && tap_ok) begin
            prod_next = ACC_W'(MW'(mul_a) * MW'(tap_weight(tap_off, wts)));
        end
        sum      = acc_reg + prod_reg;
        pop      = (state_reg == BK_IDLE) && !empty;
        out_load = (state_reg == BK_OUT) && (!out_valid_reg || m_ready);

        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!empty) state_next = BK_VERT;
            BK_VERT: if (phase_done) state_next = cur_reg.produce ? BK_HORZ : BK_IDLE;
            BK_HORZ: if (phase_done) state_next = BK_OUT;
            BK_OUT:  if (out_load) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase

        m_valid = out_valid_reg;
        m_pixel = out_pix_reg;
        m_last  = out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_reg <= line_mem[head_item.col[AW-1:0]];
        end
        if (state_reg == BK_VERT && step_reg == '0) begin
            line_mem[cur_reg.col[AW-1:0]] <= {rd_reg[LANES*8-9:0], cur_reg.pixel};
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg  <= head_item;
            prod_reg <= '0;
            acc_reg  <= '0;
        end else if (state_reg == BK_VERT || state_reg == BK_HORZ) begin
            if (phase_done) begin
                prod_reg <= '0;
                acc_reg  <= '0;
                if (state_reg == BK_VERT) begin
                    for (int k = 0; k < NT - 1; k++) begin
                        vs_reg[k] <= vs_reg[k+1];
                    end
                    vs_reg[NT-1] <= VS_W'(sum);
                end else begin
                    res_reg <= (|sum[ACC_W-1:FRAC_SHIFT+8]) ? 8'hFF
                                                            : sum[FRAC_SHIFT +: 8];
                end
            end else begin
                prod_reg <= prod_next;
                acc_reg  <= sum;
            end
        end
        if (out_load) begin
            out_pix_reg  <= res_reg;
            out_last_reg <= cur_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop || phase_done) begin
                step_reg <= '0;
            end else if (state_reg == BK_VERT || state_reg == BK_HORZ) begin
                step_reg <= step_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    ast_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_W'(NT))
        else $error("tap step past kernel size");

    ast_horz_produce: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_HORZ) |-> cur_reg.produce)
        else $error("output pass on an item that produces nothing");

    ast_out_after_horz: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == BK_OUT) |-> $past(state_reg) == BK_HORZ)
        else $error("result stage entered without a horizontal pass");

endmodule

### design/gaussian_blur_9x9.sv
// Requests are queued and processed one at a time by the single shared multiply-accumulate
// unit, doing a vertical pass and, when the request yields a result, a horizontal pass;
// the next request is taken from the queue only after the current one is finished.
// Reset (aresetn low, synchronous): counters, queue and sequencer cleared, registers to
// defaults; line memory is not cleared, rows outside the frame are masked.
module gaussian_blur_9x9
    import gb9_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int KERNEL_RADIUS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel_in
    input  logic             s_tuser,   // [0] is_flush
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] pixel_out
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [GEO_W-1:0] width_reg, height_reg;
    gb9_weights_t     wts_reg;
    logic             restart;
    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             push, pop, empty, full;
    gb9_item_t        push_item, head_item;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = COL_W'(1);
        end else if (COL_W'(width_reg) > COL_W'(MAX_WIDTH)) begin
            eff_w = COL_W'(MAX_WIDTH);
        end else begin
            eff_w = COL_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = ROW_W'(1);
        end else if (height_reg > ROW_W'(MAX_HEIGHT)) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
        restart  = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
        s_tready = !full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= GEO_W'(1024);
            height_reg <= GEO_W'(1024);
            wts_reg[0] <= WT_W'(15492);
            wts_reg[1] <= WT_W'(13031);
            wts_reg[2] <= WT_W'(7754);
            wts_reg[3] <= WT_W'(3265);
            wts_reg[4] <= WT_W'(973);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata[GEO_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[GEO_W-1:0];
                REG_WT0:    wts_reg[0] <= cfg_wdata;
                REG_WT1:    wts_reg[1] <= cfg_wdata;
                REG_WT2:    wts_reg[2] <= cfg_wdata;
                REG_WT3:    wts_reg[3] <= cfg_wdata;
                REG_WT4:    wts_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gb9_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .KERNEL_RADIUS (KERNEL_RADIUS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_tvalid && s_tready),
        .pixel_in (s_tdata),
        .is_flush (s_tuser),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .restart  (restart),
        .push     (push),
        .item     (push_item)
    );

    gb9_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (empty),
        .full      (full)
    );

    gb9_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .KERNEL_RADIUS (KERNEL_RADIUS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .empty     (empty),
        .pop       (pop),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .wts       (wts_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_pixel   (m_tdata),
        .m_last    (m_tlast)
    );

endmodule

### test/gaussian_blur_9x9_check.sv
module gaussian_blur_9x9_check
    import gb9_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel_in
    input  logic             s_tuser,   // [0] is_flush
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,   // [7:0] pixel_out
    input  logic             m_tlast,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIUS = 4;
    localparam int LIMIT_W = 1024;
    localparam int RING = 2 * RADIUS * LIMIT_W + 2 * RADIUS + 1;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } blurred_t;

    logic [GEO_W-1:0] img_w;
    logic [GEO_W-1:0] img_h;
    logic [WT_W-1:0]  wt [NUM_WTS];
    logic [7:0]       ring [RING];
    int unsigned      item_cnt;
    int unsigned      ring_pos;
    blurred_t         blurred_q [$];

    // returns 1 when the request yields a blurred pixel
    function automatic bit blur_step(input logic [7:0] pix, input logic fl,
                                     output blurred_t res);
        int unsigned w, h, total, lag, k, addr, back;
        int orow, ocol, r, c;
        longint unsigned acc;
        bit last;
        w = (img_w == 0) ? 1 : (img_w > LIMIT_W) ? LIMIT_W : img_w;
        h = (img_h == 0) ? 1 : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
        total = w * h;
        lag = RADIUS * w + RADIUS;
        last = 0;
        res = '0;
        if (item_cnt < total) begin
            if (fl) return 0;
            ring[ring_pos] = pix;
        end
        blur_step = 0;
        if (item_cnt >= lag) begin
            k = item_cnt - lag;
            orow = k / w;
            ocol = k % w;
            acc = 0;
            for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
                r = orow + dy;
                if (r < 0 || r >= int'(h)) continue;
                for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
                    c = ocol + dx;
                    if (c < 0 || c >= int'(w)) continue;
                    back = int'(lag) - (dy * int'(w) + dx);
                    addr = (ring_pos + RING - back) % RING;
                    acc += longint'(ring[addr]) * wt[dy < 0 ? -dy : dy]
                           * wt[dx < 0 ? -dx : dx];
                end
            end
            acc = acc >> FRAC_SHIFT;
            if (acc > 255) acc = 255;
            last = (k == total - 1);
            res.pixel = acc[7:0];
            res.last = last;
            blur_step = 1;
        end
        if (last) begin
            item_cnt = 0;
            ring_pos = 0;
        end else begin
            item_cnt++;
            ring_pos = (ring_pos + 1 == RING) ? 0 : ring_pos + 1;
        end
    endfunction

    initial begin
        errors = 0;
        pending = 0;
        foreach (ring[i]) ring[i] = '0;
    end

    always @(posedge aclk) begin
        blurred_t got, want;
        if (!aresetn) begin
            img_w = GEO_W'(1024);
            img_h = GEO_W'(1024);
            wt[0] = WT_W'(15492);
            wt[1] = WT_W'(13031);
            wt[2] = WT_W'(7754);
            wt[3] = WT_W'(3265);
            wt[4] = WT_W'(973);
            item_cnt = 0;
            ring_pos = 0;
            blurred_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.pixel = m_tdata;
                got.last = m_tlast;
                if (blurred_q.size() == 0) begin
                    $display("%0t: unexpected result: actual pixel %0d last %0b",
                             $time, got.pixel, got.last);
                    errors++;
                end else begin
                    want = blurred_q.pop_front();
                    if (got.pixel !== want.pixel) begin
                        $display("%0t: pixel mismatch: expected %0d actual %0d",
                                 $time, want.pixel, got.pixel);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b actual %0b",
                                 $time, want.last, got.last);
                        errors++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_WIDTH, REG_HEIGHT: begin
                        if (cfg_index == REG_WIDTH) img_w = cfg_wdata[GEO_W-1:0];
                        else img_h = cfg_wdata[GEO_W-1:0];
                        item_cnt = 0;
                        ring_pos = 0;
                    end
                    REG_WT0, REG_WT1, REG_WT2, REG_WT3, REG_WT4: begin
                        wt[cfg_index - REG_WT0] = cfg_wdata;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (blur_step(s_tdata, s_tuser, want)) blurred_q.push_back(want);
            end
        end
        pending = blurred_q.size();
    end

endmodule

### test/gaussian_blur_9x9_test.sv
module gaussian_blur_9x9_test;
    import gb9_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_RANDOM = 0;
    localparam int PAT_WHITE  = 1;
    localparam int PAT_CHECK  = 2;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] pixel_in
    logic             s_tuser;   // [0] is_flush
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [7:0] pixel_out
    logic             m_tlast;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    int               errors;
    int               pending;
    int               send_idle;
    int               recv_stall;
    int               sent;
    int               frame_no;

    gaussian_blur_9x9 uut (.*);

    gaussian_blur_9x9_check checker_i (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic push(input logic [7:0] pix, input logic fl);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= pix;
        s_tuser <= fl;
        sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic configure(input int w, input int h, input bit load_wts,
                             input logic [4:0][15:0] wts);
        cfg_we <= 1;
        cfg_index <= REG_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge aclk);
        cfg_index <= REG_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge aclk);
        if (load_wts) begin
            for (int i = 0; i < NUM_WTS; i++) begin
                cfg_index <= REG_WT0 + IDX_W'(i);
                cfg_wdata <= wts[i];
                @(posedge aclk);
            end
        end
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic run_frame(input int w_raw, input int h_raw, input int pat,
                             input int noise);
        int w, h, lag;
        logic [7:0] pix;
        case (frame_no % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 68; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 68; end
            default: begin send_idle = 20; recv_stall = 20; end
        endcase
        frame_no++;
        w = (w_raw == 0) ? 1 : (w_raw > 1024) ? 1024 : w_raw;
        h = (h_raw == 0) ? 1 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
        lag = 4 * w + 4;
        for (int i = 0; i < w * h; i++) begin
            // stray flush inside the frame is dropped
            if ($urandom_range(99) < noise) push(8'($urandom_range(255)), 1'b1);
            case (pat)
                PAT_WHITE: pix = 8'hFF;
                PAT_CHECK: pix = ((i + i / w) % 2) ? 8'hFF : 8'h00;
                default:   pix = 8'($urandom_range(255));
            endcase
            push(pix, 1'b0);
        end
        // pixel past the frame end behaves as a flush
        for (int i = 0; i < lag; i++)
            push(8'($urandom_range(255)), $urandom_range(99) >= noise);
        drain();
    endtask

    initial begin
        logic [4:0][15:0] wts;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        cfg_we = 0;
        cfg_index = REG_WIDTH;
        cfg_wdata = 0;
        send_idle = 0;
        recv_stall = 0;
        sent = 0;
        frame_no = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        wts = '0;
        configure(5, 3, 0, wts);
        run_frame(5, 3, PAT_CHECK, 20);
        wts = {5{16'hFFFF}};
        configure(3, 2, 1, wts);
        run_frame(3, 2, PAT_WHITE, 0);
        wts = '0;
        configure(0, 0, 1, wts);
        run_frame(0, 0, PAT_RANDOM, 50);
        wts = {16'd973, 16'd3265, 16'd7754, 16'd13031, 16'd15492};
        configure(1, 2047, 1, wts);
        run_frame(1, 2047, PAT_RANDOM, 5);

        while (sent < 1350) begin
            int w, h;
            bit new_wts;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            new_wts = ($urandom_range(3) == 0);
            if (new_wts) begin
                for (int i = 0; i < NUM_WTS; i++)
                    wts[i] = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(20000));
            end
            configure(w, h, new_wts, wts);
            run_frame(w, h, ($urandom_range(9) == 0) ? PAT_WHITE : PAT_RANDOM,
                      $urandom_range(10));
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
design/gb9_pkg.sv
design/gb9_fifo.sv
design/gb9_front.sv
design/gb9_back.sv
design/gaussian_blur_9x9.sv
test/gaussian_blur_9x9_check.sv
test/gaussian_blur_9x9_test.sv
